[src/kf1d_pkg.sv]
// ----------------------------------------------------------------------------
// kf1d_pkg: shared types and constants
// Widths, sequencer states, datapath control and status bundles used by the
// 1-D Kalman measurement update.
// ----------------------------------------------------------------------------
package kf1d_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;
    // |observation - mean| needs one bit more than the data
    localparam int MAG_W     = DATA_W + 1;
    localparam int CNT_W     = 6;

    localparam int SQ_LAST        = 3;
    localparam int MUL_LAST       = 4;
    localparam int DIV_MEAN_STEPS = MAG_W;
    localparam int DIV_DEV_STEPS  = 64;
    localparam int SQRT_STEPS     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSITION_NOISE  = 2'd0,
        CFG_SENSOR_NOISE      = 2'd1,
        CFG_INITIAL_MEAN      = 2'd2,
        CFG_INITIAL_DEVIATION = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CHK,
        ST_MUL1,
        ST_LD1,
        ST_DIV1,
        ST_MEAN,
        ST_MUL2,
        ST_LD2,
        ST_DIV2,
        ST_LDSQ,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MS_DEV,
        MS_TN,
        MS_SN,
        MS_PMAG,
        MS_PZ2
    } t_mul_src;

    typedef enum logic [1:0] {
        SQ_NONE,
        SQ_LD_P,
        SQ_ADD_P,
        SQ_LD_H
    } t_sq_op;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_DIV_MEAN,
        LD_DIV_DEV,
        LD_SQRT
    } t_ld_op;

    typedef struct packed {
        logic     ld_in;
        logic     mul_en;
        t_mul_src mul_src;
        logic [1:0] mul_pp;
        t_sq_op   sq_op;
        logic     acc_clr;
        logic     acc_add;
        t_ld_op   ld_op;
        logic     step_en;
        logic     step_sqrt;
        logic     mean_ld;
    } t_dp_ctrl;

    typedef struct packed {
        logic              h_zero;
        logic [DATA_W-1:0] new_mean;
        logic [DATA_W-1:0] new_dev;
    } t_dp_stat;

endpackage

[src/kf1d_in_if.sv]
// ----------------------------------------------------------------------------
// kf1d_in_if: observation channel
// Valid/ready channel carrying one signed Q-format observation per request.
// ----------------------------------------------------------------------------
interface kf1d_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [kf1d_pkg::DATA_W-1:0] observation;

    modport source (output valid, output observation, input ready);
    modport sink   (input valid, input observation, output ready);
endinterface

[src/kf1d_out_if.sv]
// ----------------------------------------------------------------------------
// kf1d_out_if: estimate channel
// Valid/ready channel carrying the updated mean, deviation and degenerate flag.
// ----------------------------------------------------------------------------
interface kf1d_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kf1d_pkg::DATA_W-1:0] mean;
    logic        [kf1d_pkg::DATA_W-1:0] deviation;
    logic                                degenerate;

    modport source (output valid, output mean, output deviation, output degenerate,
                    input ready);
    modport sink   (input valid, input mean, input deviation, input degenerate,
                    output ready);
endinterface

[src/kf1d_dpath.sv]
// ----------------------------------------------------------------------------
// kf1d_dpath: shared arithmetic datapath
// One 32x32 multiplier with a 128-bit accumulator and one 64-bit
// compare/subtract unit shared by restoring division and integer square root.
// ----------------------------------------------------------------------------
module kf1d_dpath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kf1d_pkg::t_dp_ctrl                 i_ctrl,
    input  logic signed [kf1d_pkg::DATA_W-1:0] i_observation,
    input  logic        [kf1d_pkg::DATA_W-1:0] i_est_mean,
    input  logic        [kf1d_pkg::DATA_W-1:0] i_est_dev,
    input  logic        [kf1d_pkg::DATA_W-1:0] i_tn,
    input  logic        [kf1d_pkg::DATA_W-1:0] i_sn,
    output kf1d_pkg::t_dp_stat                 o_stat
);

    localparam int MW = kf1d_pkg::MAG_W;

    logic [63:0]  r_prod;
    logic [1:0]   r_prod_sh;
    logic [63:0]  r_p;
    logic [63:0]  r_z2;
    logic [63:0]  r_h;
    logic [127:0] r_acc;
    logic [63:0]  r_rem;
    logic [127:0] r_num;
    logic [31:0]  r_root;
    logic [MW-1:0] r_mag;
    logic          r_neg;
    logic [31:0]   r_nm;

    logic [MW-1:0] diff;
    logic [MW-1:0] mag;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_res;
    logic [1:0]    pp_sh;
    logic [63:0]   prod_shr;
    logic [127:0]  acc_addend;
    logic [127:0]  acc_sh;
    logic [63:0]   sub_a;
    logic [63:0]   sub_b;
    logic [64:0]   sub_res;
    logic          ge;
    logic [63:0]   sub_keep;
    logic [33:0]   mean_ext;
    logic [33:0]   q_ext;
    logic [33:0]   mean_sum;
    logic [31:0]   mean_sat;

    // signed difference and its magnitude
    assign diff = {i_observation[31], i_observation} - {i_est_mean[31], i_est_mean};
    assign mag  = diff[MW-1] ? (~diff + {{(MW-1){1'b0}}, 1'b1}) : diff;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.mul_src)
            kf1d_pkg::MS_DEV: begin
                mul_a = i_est_dev;
                mul_b = i_est_dev;
            end
            kf1d_pkg::MS_TN: begin
                mul_a = i_tn;
                mul_b = i_tn;
            end
            kf1d_pkg::MS_SN: begin
                mul_a = i_sn;
                mul_b = i_sn;
            end
            kf1d_pkg::MS_PMAG: begin
                mul_a = i_ctrl.mul_pp[1] ? r_p[63:32] : r_p[31:0];
                mul_b = i_ctrl.mul_pp[0] ? {31'b0, r_mag[MW-1]} : r_mag[31:0];
            end
            kf1d_pkg::MS_PZ2: begin
                mul_a = i_ctrl.mul_pp[1] ? r_p[63:32] : r_p[31:0];
                mul_b = i_ctrl.mul_pp[0] ? r_z2[63:32] : r_z2[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res  = mul_a * mul_b;
    assign pp_sh    = {1'b0, i_ctrl.mul_pp[0]} + {1'b0, i_ctrl.mul_pp[1]};
    assign prod_shr = r_prod >> FRAC_BITS;
    assign acc_sh   = r_acc << FRAC_BITS;

    always_comb begin
        case (r_prod_sh)
            2'd0:    acc_addend = {64'b0, r_prod};
            2'd1:    acc_addend = {32'b0, r_prod, 32'b0};
            2'd2:    acc_addend = {r_prod, 64'b0};
            default: acc_addend = '0;
        endcase
    end

    // shared compare/subtract: division step or square root step
    always_comb begin
        if (i_ctrl.step_sqrt) begin
            sub_a = {28'b0, r_rem[33:0], r_num[127:126]};
            sub_b = {30'b0, r_root, 2'b01};
        end else begin
            sub_a = {r_rem[62:0], r_num[127]};
            sub_b = r_h;
        end
    end

    assign sub_res  = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge       = ~sub_res[64];
    assign sub_keep = ge ? sub_res[63:0] : sub_a;

    // correction is never larger than the distance, so only the rare wrap saturates
    assign mean_ext = {{2{i_est_mean[31]}}, i_est_mean};
    assign q_ext    = {1'b0, r_num[MW-1:0]};
    assign mean_sum = r_neg ? (mean_ext - q_ext) : (mean_ext + q_ext);

    always_comb begin
        if (mean_sum[33:31] == 3'b000 || mean_sum[33:31] == 3'b111) begin
            mean_sat = mean_sum[31:0];
        end else if (mean_sum[33]) begin
            mean_sat = 32'h8000_0000;
        end else begin
            mean_sat = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_in) begin
            r_mag <= mag;
            r_neg <= diff[MW-1];
        end
        if (i_ctrl.mul_en) begin
            r_prod    <= mul_res;
            r_prod_sh <= pp_sh;
        end
        case (i_ctrl.sq_op)
            kf1d_pkg::SQ_LD_P:  r_p <= prod_shr;
            kf1d_pkg::SQ_ADD_P: r_p <= r_p + prod_shr;
            kf1d_pkg::SQ_LD_H: begin
                r_z2 <= prod_shr;
                r_h  <= r_p + prod_shr;
            end
            default: ;
        endcase
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + acc_addend;
        end
        case (i_ctrl.ld_op)
            kf1d_pkg::LD_DIV_MEAN: begin
                r_rem <= r_acc[MW+63:MW];
                r_num <= {r_acc[MW-1:0], {(128-MW){1'b0}}};
            end
            kf1d_pkg::LD_DIV_DEV: begin
                r_rem <= acc_sh[127:64];
                r_num <= {acc_sh[63:0], 64'b0};
            end
            kf1d_pkg::LD_SQRT: begin
                r_rem  <= '0;
                r_num  <= {r_num[63:0], 64'b0};
                r_root <= '0;
            end
            default: begin
                if (i_ctrl.step_en) begin
                    r_rem <= sub_keep;
                    if (i_ctrl.step_sqrt) begin
                        r_num  <= {r_num[125:0], 2'b00};
                        r_root <= {r_root[30:0], ge};
                    end else begin
                        r_num <= {r_num[126:0], ge};
                    end
                end
            end
        endcase
        if (i_ctrl.mean_ld) begin
            r_nm <= mean_sat;
        end
    end

    assign o_stat.h_zero   = (r_h == 64'b0);
    assign o_stat.new_mean = r_nm;
    assign o_stat.new_dev  = r_root;

    // quotient of the mean division must fit its 33 steps
    a_div_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.ld_op == kf1d_pkg::LD_DIV_MEAN) |-> (r_acc[127:MW] < {31'b0, r_h}))
        else $error("mean division numerator out of range");

    a_div_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.ld_op == kf1d_pkg::LD_DIV_DEV) |-> (acc_sh[127:64] < r_h))
        else $error("deviation division numerator out of range");

    // gain is at most one: correction never passes the observation
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.mean_ld |-> (r_num[MW-1:0] <= r_mag))
        else $error("mean correction larger than innovation");

endmodule

[src/kalman_filter_1d_update_unit.sv]
// ----------------------------------------------------------------------------
// kalman_filter_1d_update_unit: 1-D Kalman measurement update
// Merges each observation into a stored Q-format mean and deviation.
// ----------------------------------------------------------------------------
// Usage:
//   i_obs carries one signed observation per request (valid/ready).
//   o_res returns one result per request: new mean, new deviation, and
//   degenerate when the innovation variance h was zero (state kept).
//   The config port writes transition noise, sensor noise, and the initial
//   mean/deviation; writing an initial value loads the stored estimate.
//   Write config only while no request is in flight.
// Sequence:
//   A normal update runs from accept to o_res.valid through the squares, two
//   4-product multiplies on the shared 32x32 multiplier, a 33-step and a
//   64-step restoring division and a 32-step square root on the shared
//   subtractor. A degenerate update skips the multiplies, divisions and root.
//   i_obs.ready is high only while the sequencer is idle, so one request is
//   in work at a time; the next is taken only once the sequencer is idle again.
// Reset and stall:
//   Synchronous reset sets noise values and deviation to 1.0 and mean to 0.
//   The result sits in an output register; the next request may be accepted
//   while it waits, but that request holds at its end until o_res drains.
// ----------------------------------------------------------------------------
module kalman_filter_1d_update_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [kf1d_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [kf1d_pkg::DATA_W-1:0]          i_cfg_data,
    kf1d_in_if.sink                              i_obs,
    kf1d_out_if.source                           o_res
);

    localparam int DW = kf1d_pkg::DATA_W;
    localparam logic [DW-1:0] ONE_Q = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;

    kf1d_pkg::t_state                r_state;
    kf1d_pkg::t_state                n_state;
    logic [kf1d_pkg::CNT_W-1:0]      r_cnt;
    logic [kf1d_pkg::CNT_W-1:0]      n_cnt;
    logic [DW-1:0]                   r_tn;
    logic [DW-1:0]                   r_sn;
    logic [DW-1:0]                   r_est_mean;
    logic [DW-1:0]                   r_est_dev;
    logic                            r_degen;
    logic                            r_out_valid;
    logic [DW-1:0]                   r_out_mean;
    logic [DW-1:0]                   r_out_dev;
    logic                            r_out_degen;

    kf1d_pkg::t_dp_ctrl              ctrl;
    kf1d_pkg::t_dp_stat              stat;
    logic                            obs_ready;
    logic                            out_load;
    logic                            slot_free;

    assign slot_free = ~r_out_valid | o_res.ready;

    kf1d_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_observation (i_obs.observation),
        .i_est_mean    (r_est_mean),
        .i_est_dev     (r_est_dev),
        .i_tn          (r_tn),
        .i_sn          (r_sn),
        .o_stat        (stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kf1d_pkg::ST_IDLE: begin
                if (i_obs.valid) n_state = kf1d_pkg::ST_SQ;
            end
            kf1d_pkg::ST_SQ: begin
                if (r_cnt == kf1d_pkg::CNT_W'(kf1d_pkg::SQ_LAST)) n_state = kf1d_pkg::ST_CHK;
            end
            kf1d_pkg::ST_CHK: begin
                n_state = stat.h_zero ? kf1d_pkg::ST_OUT : kf1d_pkg::ST_MUL1;
            end
            kf1d_pkg::ST_MUL1: begin
                if (r_cnt == kf1d_pkg::CNT_W'(kf1d_pkg::MUL_LAST)) n_state = kf1d_pkg::ST_LD1;
            end
            kf1d_pkg::ST_LD1: n_state = kf1d_pkg::ST_DIV1;
            kf1d_pkg::ST_DIV1: begin
                if (r_cnt == kf1d_pkg::CNT_W'(kf1d_pkg::DIV_MEAN_STEPS - 1)) begin
                    n_state = kf1d_pkg::ST_MEAN;
                end
            end
            kf1d_pkg::ST_MEAN: n_state = kf1d_pkg::ST_MUL2;
            kf1d_pkg::ST_MUL2: begin
                if (r_cnt == kf1d_pkg::CNT_W'(kf1d_pkg::MUL_LAST)) n_state = kf1d_pkg::ST_LD2;
            end
            kf1d_pkg::ST_LD2: n_state = kf1d_pkg::ST_DIV2;
            kf1d_pkg::ST_DIV2: begin
                if (r_cnt == kf1d_pkg::CNT_W'(kf1d_pkg::DIV_DEV_STEPS - 1)) begin
                    n_state = kf1d_pkg::ST_LDSQ;
                end
            end
            kf1d_pkg::ST_LDSQ: n_state = kf1d_pkg::ST_SQRT;
            kf1d_pkg::ST_SQRT: begin
                if (r_cnt == kf1d_pkg::CNT_W'(kf1d_pkg::SQRT_STEPS - 1)) begin
                    n_state = kf1d_pkg::ST_OUT;
                end
            end
            kf1d_pkg::ST_OUT: begin
                if (slot_free) n_state = kf1d_pkg::ST_IDLE;
            end
            default: n_state = kf1d_pkg::ST_IDLE;
        endcase
        n_cnt = (n_state != r_state) ? '0 : r_cnt + 1'b1;
    end

    // sequencer outputs
    always_comb begin
        ctrl      = '0;
        obs_ready = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            kf1d_pkg::ST_IDLE: begin
                obs_ready  = 1'b1;
                ctrl.ld_in = i_obs.valid;
            end
            kf1d_pkg::ST_SQ: begin
                // each product is registered, then folded from r_prod into p or h
                case (r_cnt[1:0])
                    2'd0: begin
                        ctrl.mul_en  = 1'b1;
                        ctrl.mul_src = kf1d_pkg::MS_DEV;
                    end
                    2'd1: begin
                        ctrl.mul_en  = 1'b1;
                        ctrl.mul_src = kf1d_pkg::MS_TN;
                        ctrl.sq_op   = kf1d_pkg::SQ_LD_P;
                    end
                    2'd2: begin
                        ctrl.mul_en  = 1'b1;
                        ctrl.mul_src = kf1d_pkg::MS_SN;
                        ctrl.sq_op   = kf1d_pkg::SQ_ADD_P;
                    end
                    default: ctrl.sq_op = kf1d_pkg::SQ_LD_H;
                endcase
            end
            kf1d_pkg::ST_CHK: ctrl.acc_clr = 1'b1;
            kf1d_pkg::ST_MUL1: begin
                ctrl.mul_en  = (r_cnt < kf1d_pkg::CNT_W'(kf1d_pkg::MUL_LAST));
                ctrl.mul_src = kf1d_pkg::MS_PMAG;
                ctrl.mul_pp  = r_cnt[1:0];
                ctrl.acc_add = (r_cnt != '0);
            end
            kf1d_pkg::ST_LD1: begin
                ctrl.ld_op   = kf1d_pkg::LD_DIV_MEAN;
                ctrl.acc_clr = 1'b1;
            end
            kf1d_pkg::ST_DIV1: ctrl.step_en = 1'b1;
            kf1d_pkg::ST_MEAN: ctrl.mean_ld = 1'b1;
            kf1d_pkg::ST_MUL2: begin
                ctrl.mul_en  = (r_cnt < kf1d_pkg::CNT_W'(kf1d_pkg::MUL_LAST));
                ctrl.mul_src = kf1d_pkg::MS_PZ2;
                ctrl.mul_pp  = r_cnt[1:0];
                ctrl.acc_add = (r_cnt != '0);
            end
            kf1d_pkg::ST_LD2: ctrl.ld_op = kf1d_pkg::LD_DIV_DEV;
            kf1d_pkg::ST_DIV2: ctrl.step_en = 1'b1;
            kf1d_pkg::ST_LDSQ: ctrl.ld_op = kf1d_pkg::LD_SQRT;
            kf1d_pkg::ST_SQRT: begin
                ctrl.step_en   = 1'b1;
                ctrl.step_sqrt = 1'b1;
            end
            kf1d_pkg::ST_OUT: out_load = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kf1d_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_tn        <= ONE_Q;
            r_sn        <= ONE_Q;
            r_est_mean  <= '0;
            r_est_dev   <= ONE_Q;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load && !r_degen) begin
                r_est_mean <= stat.new_mean;
                r_est_dev  <= stat.new_dev;
            end
            if (i_cfg_we) begin
                unique case (kf1d_pkg::t_cfg_idx'(i_cfg_idx))
                    kf1d_pkg::CFG_TRANSITION_NOISE:  r_tn       <= i_cfg_data;
                    kf1d_pkg::CFG_SENSOR_NOISE:      r_sn       <= i_cfg_data;
                    kf1d_pkg::CFG_INITIAL_MEAN:      r_est_mean <= i_cfg_data;
                    kf1d_pkg::CFG_INITIAL_DEVIATION: r_est_dev  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kf1d_pkg::ST_CHK) begin
            r_degen <= stat.h_zero;
        end
        if (out_load) begin
            r_out_mean  <= r_degen ? r_est_mean : stat.new_mean;
            r_out_dev   <= r_degen ? r_est_dev : stat.new_dev;
            r_out_degen <= r_degen;
        end
    end

    assign i_obs.ready      = obs_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.mean       = r_out_mean;
    assign o_res.deviation  = r_out_dev;
    assign o_res.degenerate = r_out_degen;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_obs.valid && i_obs.ready) |=> (r_state == kf1d_pkg::ST_SQ))
        else $error("accepted request did not start the sequence");

    a_zero_h_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kf1d_pkg::ST_CHK && stat.h_zero)
        |=> (r_state == kf1d_pkg::ST_OUT && r_degen))
        else $error("zero innovation variance not flagged");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kf1d_pkg::ST_OUT && slot_free)
        |=> (r_out_valid && r_state == kf1d_pkg::ST_IDLE))
        else $error("finished result not presented");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kalman_filter_1d_update_unit
// Feeds observations over the valid/ready channel and checks each returned
// estimate against an in-bench fixed-point model of the measurement update.
// Covers degenerate, zero-gain and saturating settings, then random traffic
// under varying backpressure, including a long output stall in each profile.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC_BITS   = 16;
    localparam int HOLD_CYCLES = 800;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic signed [kf1d_pkg::DATA_W-1:0] mean;
        logic [kf1d_pkg::DATA_W-1:0]        deviation;
        logic                               degenerate;
    } t_estimate;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                               cfg_we    = 1'b0;
    kf1d_pkg::t_cfg_idx                 cfg_idx   = kf1d_pkg::CFG_TRANSITION_NOISE;
    logic [kf1d_pkg::DATA_W-1:0]        cfg_data  = '0;
    logic                               obs_valid = 1'b0;
    logic signed [kf1d_pkg::DATA_W-1:0] obs_data  = '0;
    logic                               res_ready = 1'b0;

    kf1d_in_if  obs_if();
    kf1d_out_if res_if();

    assign obs_if.valid       = obs_valid;
    assign obs_if.observation = obs_data;
    assign res_if.ready       = res_ready;

    kalman_filter_1d_update_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_obs     (obs_if.sink),
        .o_res     (res_if.source)
    );

    // filter state and noise settings mirrored from the register writes
    logic [kf1d_pkg::DATA_W-1:0] noise_proc = 32'h0001_0000;
    logic [kf1d_pkg::DATA_W-1:0] noise_meas = 32'h0001_0000;
    logic [kf1d_pkg::DATA_W-1:0] flt_mean   = 32'h0000_0000;
    logic [kf1d_pkg::DATA_W-1:0] flt_dev    = 32'h0001_0000;

    logic signed [kf1d_pkg::DATA_W-1:0] obs_q[$];
    t_estimate                          estimate_q[$];
    t_estimate                          got, want;

    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   err_count    = 0;
    int   hold_left    = 0;
    logic hold_trig    = 1'b0;
    logic hold_seen    = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic logic [63:0] sq_frac(input logic [kf1d_pkg::DATA_W-1:0] x);
        logic [63:0] prod;
        prod = {32'd0, x} * {32'd0, x};
        return prod >> FRAC_BITS;
    endfunction

    function automatic logic [63:0] clip_u64(input logic [127:0] x);
        return (x[127:64] != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : x[63:0];
    endfunction

    function automatic logic [kf1d_pkg::DATA_W-1:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem, root, probe;
        rem   = v;
        root  = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 64'd0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[kf1d_pkg::DATA_W-1:0];
    endfunction

    // merges one observation into the mirrored estimate
    function automatic t_estimate update_estimate(input logic [kf1d_pkg::DATA_W-1:0] obs);
        t_estimate          outcome;
        logic [63:0]        var_prior, var_sensor, var_innov, corr;
        logic [127:0]       quo;
        logic signed [34:0] diff, moved;
        logic [34:0]        mag;
        var_prior  = sq_frac(flt_dev) + sq_frac(noise_proc);
        var_sensor = sq_frac(noise_meas);
        var_innov  = var_prior + var_sensor;
        if (var_innov == 64'd0) begin
            outcome.mean       = flt_mean;
            outcome.deviation  = flt_dev;
            outcome.degenerate = 1'b1;
            return outcome;
        end
        diff = $signed({{3{obs[31]}}, obs}) - $signed({{3{flt_mean[31]}}, flt_mean});
        mag  = (diff < 0) ? -diff : diff;
        quo  = ({64'd0, var_prior} * {93'd0, mag}) / {64'd0, var_innov};
        corr = clip_u64(quo);
        // correction never moves past the observation
        if (corr > {29'd0, mag}) corr = {29'd0, mag};
        if (diff < 0) begin
            moved = $signed({{3{flt_mean[31]}}, flt_mean}) - $signed({1'b0, corr[33:0]});
        end else begin
            moved = $signed({{3{flt_mean[31]}}, flt_mean}) + $signed({1'b0, corr[33:0]});
        end
        if (moved > 35'sd2147483647) begin
            flt_mean = 32'h7FFF_FFFF;
        end else if (moved < -35'sd2147483648) begin
            flt_mean = 32'h8000_0000;
        end else begin
            flt_mean = moved[31:0];
        end
        quo     = (({64'd0, var_prior} * {64'd0, var_sensor}) << FRAC_BITS)
                  / {64'd0, var_innov};
        flt_dev = int_sqrt(clip_u64(quo));
        outcome.mean       = flt_mean;
        outcome.deviation  = flt_dev;
        outcome.degenerate = 1'b0;
        return outcome;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            obs_valid <= 1'b0;
        end else begin
            if (obs_valid && obs_if.ready) begin
                estimate_q.push_back(update_estimate(obs_data));
            end
            if (!obs_valid || obs_if.ready) begin
                if (obs_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    obs_valid <= 1'b1;
                    obs_data  <= obs_q.pop_front();
                end else begin
                    obs_valid <= 1'b0;
                end
            end
        end
    end

    // long output stall, counted here
    always @(posedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_if.valid && res_ready) begin
                got.mean       = res_if.mean;
                got.deviation  = res_if.deviation;
                got.degenerate = res_if.degenerate;
                if (estimate_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result mean=%h dev=%h",
                                            got.mean, got.deviation));
                end else begin
                    want = estimate_q.pop_front();
                    if (got.mean !== want.mean) begin
                        flag_mismatch($sformatf("mean %h, expected %h",
                                                got.mean, want.mean));
                    end
                    if (got.deviation !== want.deviation) begin
                        flag_mismatch($sformatf("deviation %h, expected %h",
                                                got.deviation, want.deviation));
                    end
                    if (got.degenerate !== want.degenerate) begin
                        flag_mismatch($sformatf("degenerate %b, expected %b",
                                                got.degenerate, want.degenerate));
                    end
                end
            end
            res_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic write_reg(input kf1d_pkg::t_cfg_idx idx,
                             input logic [kf1d_pkg::DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            kf1d_pkg::CFG_TRANSITION_NOISE:  noise_proc = val;
            kf1d_pkg::CFG_SENSOR_NOISE:      noise_meas = val;
            kf1d_pkg::CFG_INITIAL_MEAN:      flt_mean   = val;
            kf1d_pkg::CFG_INITIAL_DEVIATION: flt_dev    = val;
            default: ;
        endcase
    endtask

    // wait until every request is through and its result has drained
    task automatic settle();
        do @(negedge i_clk);
        while (obs_q.size() != 0 || obs_valid || estimate_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send(input logic [kf1d_pkg::DATA_W-1:0] obs);
        obs_q.push_back(obs);
    endtask

    function automatic logic [kf1d_pkg::DATA_W-1:0] pick_noise();
        case ($urandom_range(5))
            0: return $urandom_range(255);
            1: return $urandom_range(32'h0000_8000, 32'h0004_0000);
            2: return $urandom_range(32'h00FF_FFFF);
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [kf1d_pkg::DATA_W-1:0] pick_obs();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return $urandom;
        if (sel < 85) return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    initial begin
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults: unit noise, zero mean
        send(32'h0000_0000);
        send(32'h7FFF_FFFF);
        send(32'h8000_0000);
        send(32'hFFFF_FFFF);
        send(32'h0000_0001);
        send(32'h0001_0000);
        settle();

        // all noise zero: state kept, flagged
        write_reg(kf1d_pkg::CFG_TRANSITION_NOISE, 32'h0);
        write_reg(kf1d_pkg::CFG_SENSOR_NOISE, 32'h0);
        write_reg(kf1d_pkg::CFG_INITIAL_DEVIATION, 32'h0);
        @(negedge i_clk);
        send(32'h1234_5678);
        send(32'h8000_0000);
        settle();

        // squares truncate to zero just below one lsb
        write_reg(kf1d_pkg::CFG_TRANSITION_NOISE, 32'd255);
        write_reg(kf1d_pkg::CFG_SENSOR_NOISE, 32'd255);
        write_reg(kf1d_pkg::CFG_INITIAL_DEVIATION, 32'd255);
        write_reg(kf1d_pkg::CFG_INITIAL_MEAN, 32'h7FFF_FFFF);
        @(negedge i_clk);
        send(32'h0000_0000);
        settle();

        // no sensor noise: mean jumps to the observation
        write_reg(kf1d_pkg::CFG_TRANSITION_NOISE, 32'd256);
        @(negedge i_clk);
        send(32'h8000_0000);
        send(32'h7FFF_FFFF);
        settle();

        // no prior variance: mean stays put
        write_reg(kf1d_pkg::CFG_TRANSITION_NOISE, 32'h0);
        write_reg(kf1d_pkg::CFG_SENSOR_NOISE, 32'hFFFF_FFFF);
        write_reg(kf1d_pkg::CFG_INITIAL_DEVIATION, 32'h0);
        @(negedge i_clk);
        send(32'h7FFF_FFFF);
        settle();

        // everything at full scale, mean at both rails
        write_reg(kf1d_pkg::CFG_TRANSITION_NOISE, 32'hFFFF_FFFF);
        write_reg(kf1d_pkg::CFG_INITIAL_DEVIATION, 32'hFFFF_FFFF);
        write_reg(kf1d_pkg::CFG_INITIAL_MEAN, 32'h8000_0000);
        @(negedge i_clk);
        send(32'h7FFF_FFFF);
        send(32'h8000_0000);
        settle();
        write_reg(kf1d_pkg::CFG_INITIAL_MEAN, 32'h7FFF_FFFF);
        @(negedge i_clk);
        send(32'h8000_0000);
        send(32'h0000_0000);
        settle();

        // random traffic under three backpressure profiles
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 65 : 0;
            snk_idle_pct = (mode == 0) ? 65 : (mode == 1) ? 13 : 0;
            for (int ph = 0; ph < 12; ph++) begin
                settle();
                write_reg(kf1d_pkg::CFG_TRANSITION_NOISE, pick_noise());
                write_reg(kf1d_pkg::CFG_SENSOR_NOISE, pick_noise());
                if ($urandom_range(1)) begin
                    write_reg(kf1d_pkg::CFG_INITIAL_MEAN,
                              $urandom_range(1) ? $urandom : pick_obs());
                end
                if ($urandom_range(1)) begin
                    write_reg(kf1d_pkg::CFG_INITIAL_DEVIATION, pick_noise());
                end
                @(negedge i_clk);
                n = $urandom_range(30, 50);
                for (int k = 0; k < n; k++) send(pick_obs());
                if (ph == 5) hold_trig = ~hold_trig;
            end
        end

        settle();
        repeat (200) @(negedge i_clk);
        if (err_count == 0 && estimate_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
